/* rtl/assert_macros.svh */
// Assertion helpers; expect clk and arst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define POL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define POL_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/pol_pkg.sv */
`default_nettype none
package pol_pkg;

	localparam int DATA_W = 31;

	// operation codes
	localparam logic [2:0] OP_INSERT   = 3'd0;
	localparam logic [2:0] OP_APPEND   = 3'd1;
	localparam logic [2:0] OP_DELETE   = 3'd2;
	localparam logic [2:0] OP_DEL_TAIL = 3'd3;
	localparam logic [2:0] OP_READ     = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_NEG    = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	typedef struct packed {
		logic [2:0]         operation;
		logic [4:0]         position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [DATA_W-1:0] read_value;
		logic [4:0]        entry_count;
	} rsp_t;

	// broadcast to every cell
	typedef struct packed {
		logic              ins;
		logic              del;
		logic              rd;
		logic [DATA_W-1:0] data;
	} cell_cmd_t;

endpackage
`default_nettype wire

/* rtl/positional_ordered_list.sv */
// Ordered list of up to CAPACITY 31-bit words held in a row of cells, one
// entry per cell. For each request (insert at position, append, delete at
// position, delete tail, read), all cells shift or hold together on the
// accepting edge and the result lands in the output register, so a new
// request is taken every cycle while the response side keeps up. The
// response register is the only buffering; while a response waits,
// req_ready is low. Every request gives exactly one response with
// status, read data (zero unless a successful read) and the entry count after
// the request, reported modulo 32. No clearing pass: the count resets to zero
// and only cells below it are ever read.
`default_nettype none
module positional_ordered_list import pol_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req_data,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp_data
);

	`include "assert_macros.svh"

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int EW    = (CNT_W > 5) ? CNT_W : 5;

	logic              accept;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_next;
	cell_cmd_t         cmd;
	logic [IDX_W-1:0]  at;
	logic [1:0]        status;
	logic [EW-1:0]     count_ext;
	logic [DATA_W-1:0] rd_any;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	// per-cell taps: stored word and gated read contribution
	logic [DATA_W-1:0] entry   [CAPACITY];
	logic [DATA_W-1:0] rd_bus  [CAPACITY];

	// one response slot; refill in the same cycle it drains
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;

	pol_ctrl #(
		.CAPACITY (CAPACITY),
		.IDX_W    (IDX_W),
		.CNT_W    (CNT_W)
	) u_ctrl (
		.req        (req_data),
		.go         (accept),
		.count      (count_q),
		.cmd        (cmd),
		.at         (at),
		.status     (status),
		.count_next (count_next)
	);

	// cell chain: each cell sees its lower and upper neighbor; ends tie off
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] lower_d;
		logic [DATA_W-1:0] upper_d;
		if (i == 0) begin : g_lo_end
			assign lower_d = '0;
		end else begin : g_lo
			assign lower_d = entry[i-1];
		end
		if (i == CAPACITY - 1) begin : g_hi_end
			assign upper_d = '0;
		end else begin : g_hi
			assign upper_d = entry[i+1];
		end
		pol_cell #(
			.IDX_W (IDX_W),
			.INDEX (i)
		) u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.at      (at),
			.lower   (lower_d),
			.upper   (upper_d),
			.entry   (entry[i]),
			.rd_data (rd_bus[i])
		);
	end

	// at most one cell drives a nonzero read word
	always_comb begin
		rd_any = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_any = rd_any | rd_bus[i];
		end
	end

	assign count_ext = EW'(count_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_next;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload, loaded with each accepted beat
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.status      <= status;
			rsp_q.read_value  <= rd_any;
			rsp_q.entry_count <= count_ext[4:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	`POL_ASSERT(a_count_bound, (count_q <= CNT_W'(CAPACITY)), "entry count above capacity")
	`POL_ASSERT(a_count_hold, (!accept |=> $stable(count_q)), "count moved without a request")
	`POL_ASSERT(a_rd_zero, ((rsp_valid && (rsp_data.status != ST_OK)) |-> (rsp_data.read_value == '0)), "failed request carries read data")
	`POL_ASSERT_ALWAYS(a_no_overrun, ((rsp_valid && !rsp_ready) |-> !req_ready), "request taken over a held response")

endmodule
`default_nettype wire

/* rtl/pol_cell.sv */
`default_nettype none
module pol_cell import pol_pkg::*; #(
	parameter int IDX_W = 4,
	parameter int INDEX = 0
) (
	input  wire logic              clk,
	input  wire cell_cmd_t         cmd,
	input  wire logic [IDX_W-1:0]  at,
	input  wire logic [DATA_W-1:0] lower,
	input  wire logic [DATA_W-1:0] upper,
	output logic      [DATA_W-1:0] entry,
	output logic      [DATA_W-1:0] rd_data
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic [DATA_W-1:0] entry_q;

	// insert: above the gap take the lower neighbor; delete: at/above take upper
	always_ff @(posedge clk) begin
		if (cmd.ins && (MY_IDX > at)) begin
			entry_q <= lower;
		end else if (cmd.ins && (MY_IDX == at)) begin
			entry_q <= cmd.data;
		end else if (cmd.del && (MY_IDX >= at)) begin
			entry_q <= upper;
		end
	end

	assign entry   = entry_q;
	assign rd_data = (cmd.rd && (MY_IDX == at)) ? entry_q : '0;

endmodule
`default_nettype wire

/* rtl/pol_ctrl.sv */
`default_nettype none
module pol_ctrl import pol_pkg::*; #(
	parameter int CAPACITY = 16,
	parameter int IDX_W    = 4,
	parameter int CNT_W    = 5
) (
	input  wire req_t              req,
	input  wire logic              go,
	input  wire logic [CNT_W-1:0]  count,
	output cell_cmd_t              cmd,
	output logic      [IDX_W-1:0]  at,
	output logic      [1:0]        status,
	output logic      [CNT_W-1:0]  count_next
);

	localparam int W = (CNT_W > 5) ? CNT_W : 5;

	logic [W-1:0] pos_w;
	logic [W-1:0] cnt_w;
	logic         full;
	logic         neg;

	assign pos_w = W'(req.position);
	assign cnt_w = W'(count);
	assign full  = (count == CNT_W'(CAPACITY));
	assign neg   = req.value[31];

	always_comb begin
		status     = ST_OK;
		cmd        = '0;
		cmd.data   = req.value[DATA_W-1:0];
		at         = pos_w[IDX_W-1:0];
		count_next = count;
		case (req.operation)
			OP_INSERT: begin
				if (neg) begin
					status = ST_NEG;
				end else if (pos_w > cnt_w) begin
					status = ST_BADPOS;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					cmd.ins    = go;
					count_next = count + CNT_W'(1);
				end
			end
			OP_APPEND: begin
				at = cnt_w[IDX_W-1:0];
				if (neg) begin
					status = ST_NEG;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					cmd.ins    = go;
					count_next = count + CNT_W'(1);
				end
			end
			OP_DELETE: begin
				if (pos_w >= cnt_w) begin
					status = ST_BADPOS;
				end else begin
					cmd.del    = go;
					count_next = count - CNT_W'(1);
				end
			end
			OP_DEL_TAIL: begin
				if (count == '0) begin
					status = ST_BADPOS;
				end else begin
					count_next = count - CNT_W'(1);
				end
			end
			OP_READ: begin
				if (pos_w >= cnt_w) begin
					status = ST_BADPOS;
				end else begin
					cmd.rd = 1'b1;
				end
			end
			default: begin
				status = ST_BADPOS;
			end
		endcase
	end

endmodule
`default_nettype wire
